// ----- rtl/multiplexed_periodic_timer_bank_top_macros.svh -----
// Assertion macros for the periodic timer bank.
`ifndef MULTIPLEXED_PERIODIC_TIMER_BANK_TOP_MACROS_SVH
`define MULTIPLEXED_PERIODIC_TIMER_BANK_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define MPTB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication
`define MPTB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define MPTB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define MPTB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ----- rtl/mptb_pkg.sv -----
package mptb_pkg;

   localparam int PERIOD_W  = 32;
   localparam int INDEX_W   = 3;
   localparam int CFG_W     = 4;
   localparam int MASK_BITS = 8;

   localparam logic [CFG_W-1:0]    CFG_RESET      = 4'd8;
   localparam logic [PERIOD_W-1:0] COUNT_ALL_ONES = '1;

   // Request codes; the fourth code is unused
   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_START = 2'd1,
      REQ_STOP  = 2'd2
   } req_code_type;

   typedef struct packed {
      logic [1:0]          req_type;
      logic [INDEX_W-1:0]  timer_index;
      logic [PERIOD_W-1:0] period;
   } req_item_type;

   typedef struct packed {
      logic                 accepted;
      logic [MASK_BITS-1:0] fired_mask;
   } rsp_item_type;

   // Control from the pipeline to the timer bank
   typedef struct packed {
      logic             commit;
      logic [CFG_W-1:0] timers_in_use;
   } bank_ctl_type;

endpackage

// ----- rtl/mptb_if.sv -----
// Request channel
interface mptb_req_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     req_type;
   logic [mptb_pkg::INDEX_W-1:0]   timer_index;
   logic [mptb_pkg::PERIOD_W-1:0]  period;

   modport source (output valid, output req_type, output timer_index, output period,
                   input ready);
   modport sink   (input valid, input req_type, input timer_index, input period,
                   output ready);
endinterface

// Result channel
interface mptb_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            accepted;
   logic [mptb_pkg::MASK_BITS-1:0]  fired_mask;

   modport source (output valid, output accepted, output fired_mask, input ready);
   modport sink   (input valid, input accepted, input fired_mask, output ready);
endinterface

// Register write channel
interface mptb_csr_if;
   logic                         valid;
   logic                         ready;
   logic [mptb_pkg::CFG_W-1:0]   timers_in_use;

   modport source (output valid, output timers_in_use, input ready);
   modport sink   (input valid, input timers_in_use, output ready);
endinterface

// ----- rtl/mptb_timer_bank.sv -----
module mptb_timer_bank #(
   parameter int MAX_TIMERS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mptb_pkg::bank_ctl_type ctl,
   input  mptb_pkg::req_item_type item,
   output mptb_pkg::rsp_item_type result
);
   import mptb_pkg::*;

   localparam int SEL_W = 6;
   localparam int CAP   = (MAX_TIMERS > 15) ? 15 : MAX_TIMERS;
   localparam logic [CFG_W-1:0] CAP_N = CFG_W'(CAP);

   logic [PERIOD_W-1:0]   period_ff [MAX_TIMERS];
   logic [PERIOD_W-1:0]   count_ff  [MAX_TIMERS];
   logic [MAX_TIMERS-1:0] fire_vec;
   logic [CFG_W-1:0]      active_n;
   logic                  is_tick;
   logic                  is_write;
   logic                  idx_ok;

   // Number of timers in use, capped at the bank size and at 15
   assign active_n = (ctl.timers_in_use > CAP_N) ? CAP_N : ctl.timers_in_use;

   // Decode the request
   always_comb begin
      is_tick  = 1'b0;
      is_write = 1'b0;
      case (item.req_type)
         REQ_TICK:            is_tick  = 1'b1;
         REQ_START, REQ_STOP: is_write = 1'b1;
         default: begin
            is_tick  = 1'b0;
            is_write = 1'b0;
         end
      endcase
   end

   assign idx_ok = {1'b0, item.timer_index} < active_n;

   // One counter and comparator per timer
   for (genvar i = 0; i < MAX_TIMERS; i++) begin : g_timer
      logic                in_use;
      logic                idx_hit;
      logic                hit;
      logic [PERIOD_W-1:0] count_inc;

      assign in_use = SEL_W'(i) < {2'b00, active_n};

      if (i < (1 << INDEX_W)) begin : g_addr
         assign idx_hit = item.timer_index == INDEX_W'(i);
      end else begin : g_noaddr
         assign idx_hit = 1'b0;
      end

      // All ones wraps to zero before the increment
      assign count_inc = (count_ff[i] == COUNT_ALL_ONES) ? PERIOD_W'(1)
                                                         : count_ff[i] + PERIOD_W'(1);
      assign hit         = count_inc == period_ff[i];
      assign fire_vec[i] = is_tick && in_use && hit;

      always_ff @(posedge clock) begin
         if (reset) begin
            period_ff[i] <= '0;
            count_ff[i]  <= '0;
         end else if (ctl.commit) begin
            if (is_tick && in_use) begin
               count_ff[i] <= hit ? '0 : count_inc;
            end else if (is_write && idx_ok && idx_hit) begin
               period_ff[i] <= (item.req_type == REQ_START) ? item.period : '0;
               count_ff[i]  <= '0;
            end
         end
      end
   end

   // Only the first eight timers report in the mask
   for (genvar b = 0; b < MASK_BITS; b++) begin : g_mask
      if (b < MAX_TIMERS) begin : g_bit
         assign result.fired_mask[b] = fire_vec[b];
      end else begin : g_zero
         assign result.fired_mask[b] = 1'b0;
      end
   end

   assign result.accepted = is_tick || (is_write && idx_ok);

endmodule

// ----- rtl/multiplexed_periodic_timer_bank_top.sv -----
// Periodic timer bank: up to MAX_TIMERS virtual timers sharing one tick.
// req channel: req_type (tick, start, stop), timer_index and period. A start
// loads a period and clears the count, a stop loads period zero; a tick
// advances every timer in use and reports those that reached their period.
// rsp channel: one result per request, accepted flag and fired_mask.
// csr channel: write of timers_in_use, always ready; write only when idle.
// The single input register and single result register lie around the
// timer update logic; a request's result shows on rsp from the result
// register. Throughput: one request per cycle while rsp does not stall.
// A new request is taken while a result waits on a stalled receiver; when
// both registers are full req ready drops until rsp transfers.
// Reset clears all periods and counts (timers stopped), empties both
// registers and sets timers_in_use to eight.
`include "multiplexed_periodic_timer_bank_top_macros.svh"

module multiplexed_periodic_timer_bank_top #(
   parameter int MAX_TIMERS = 8
) (
   input  logic       clock,
   input  logic       reset,
   mptb_req_if.sink   req_if,
   mptb_rsp_if.source rsp_if,
   mptb_csr_if.sink   csr_if
);
   import mptb_pkg::*;

   logic             s1_valid_ff, s1_valid_in;
   req_item_type     s1_item_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_item_ff, rsp_item_in;
   logic [CFG_W-1:0] cfg_ff;
   logic             advance;
   logic             req_take;
   bank_ctl_type     bank_ctl;

   // Pipeline control
   assign advance     = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || advance;
   assign req_take    = req_if.valid && req_if.ready;
   assign s1_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input register payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff.req_type    <= req_if.req_type;
         s1_item_ff.timer_index <= req_if.timer_index;
         s1_item_ff.period      <= req_if.period;
      end
   end

   // Result register payload
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   // Configuration register
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_if.valid) begin
         cfg_ff <= csr_if.timers_in_use;
      end
   end

   // Timer state and per-request update
   assign bank_ctl.commit        = advance;
   assign bank_ctl.timers_in_use = cfg_ff;

   mptb_timer_bank #(
      .MAX_TIMERS (MAX_TIMERS)
   ) u_bank (
      .clock  (clock),
      .reset  (reset),
      .ctl    (bank_ctl),
      .item   (s1_item_ff),
      .result (rsp_item_in)
   );

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.accepted   = rsp_item_ff.accepted;
   assign rsp_if.fired_mask = rsp_item_ff.fired_mask;

   // Checks
   `MPTB_ASSERT_NEXT(a_s1_holds, clock, reset, s1_valid_ff && rsp_valid_ff && !rsp_if.ready, s1_valid_ff, "input register lost a request while the result stalled")
   `MPTB_ASSERT_NOW(a_fire_needs_accept, clock, reset, rsp_valid_ff && (rsp_item_ff.fired_mask != '0), rsp_item_ff.accepted, "timer fired on a rejected request")
   `MPTB_ASSERT_NEXT(a_cfg_write, clock, reset, csr_if.valid && csr_if.ready, cfg_ff == $past(csr_if.timers_in_use), "register write not taken")
   `MPTB_ASSERT_NOW(a_ready_full, clock, reset, !req_if.ready, s1_valid_ff && rsp_valid_ff, "request refused with a free register")

endmodule
